@@ rtl/csvt_pkg.sv @@
// ----------------------------------------------------------------------------
// csvt_pkg
// Shared types, character codes and the per-character field scanner.
// ----------------------------------------------------------------------------
package csvt_pkg;

  localparam logic [7:0] CH_LF       = 8'd10;
  localparam logic [7:0] CH_CR       = 8'd13;
  localparam logic [7:0] CH_QUOTE    = 8'd34;
  localparam logic [7:0] DELIM_RESET = 8'd44;

  localparam logic [1:0] KIND_CHAR   = 2'd0;
  localparam logic [1:0] KIND_FIELD  = 2'd1;
  localparam logic [1:0] KIND_RECORD = 2'd2;

  localparam logic [1:0] MODE_PLAIN  = 2'd0;
  localparam logic [1:0] MODE_QUOTED = 2'd1;
  localparam logic [1:0] MODE_QPEND  = 2'd2;

  localparam int MAX_EVENTS = 3;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] ch;
  } event_t;

  typedef struct packed {
    logic [1:0] mode;
    logic       emit;
    event_t     ev;
  } feed_res_t;

  typedef struct packed {
    logic [1:0] cnt;
    logic [1:0] rd;
  } buf_status_t;

  function automatic feed_res_t feed(input logic [1:0] mode, input logic [7:0] c,
                                     input logic [7:0] delim);
    feed_res_t r;
    logic      done;
    r.mode    = mode;
    r.emit    = 1'b0;
    r.ev.kind = KIND_CHAR;
    r.ev.ch   = 8'd0;
    done      = 1'b0;
    if (mode == MODE_QPEND) begin
      if (c == CH_QUOTE) begin
        r.emit  = 1'b1;
        r.ev.ch = CH_QUOTE;
        r.mode  = MODE_QUOTED;
        done    = 1'b1;
      end
    end else if (mode == MODE_QUOTED) begin
      done = 1'b1;
      if (c == CH_QUOTE) begin
        r.mode = MODE_QPEND;
      end else begin
        r.emit  = 1'b1;
        r.ev.ch = c;
      end
    end
    if (!done) begin
      r.mode = MODE_PLAIN;
      if (c == CH_LF) begin
        r.emit    = 1'b1;
        r.ev.kind = KIND_RECORD;
      end else if (c == delim) begin
        r.emit    = 1'b1;
        r.ev.kind = KIND_FIELD;
      end else if (c == CH_QUOTE) begin
        r.mode = MODE_QUOTED;
      end else begin
        r.emit  = 1'b1;
        r.ev.ch = c;
      end
    end
    return r;
  endfunction

endpackage

@@ rtl/csvt_scan.sv @@
// ----------------------------------------------------------------------------
// csvt_scan
// Holds quote mode, held CR and delimiter; turns one byte into up to three
// packed events.
// ----------------------------------------------------------------------------
module csvt_scan (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [7:0]            cfg_delim,
  input  logic                  accept,
  input  logic [7:0]            text_byte,
  input  logic                  end_of_text,
  output csvt_pkg::event_t      ev [csvt_pkg::MAX_EVENTS],
  output logic [1:0]            ev_cnt
);
  import csvt_pkg::*;

  logic [1:0] quote_mode;
  logic [1:0] quote_mode_next;
  logic       cr_held;
  logic       cr_held_next;
  logic [7:0] delim;

  feed_res_t  f1;
  feed_res_t  f2;
  feed_res_t  f3;
  logic       v1;
  logic       v2;
  logic       v3;
  logic       consumed;
  logic       hold_cr;
  logic [1:0] m1;
  logic [1:0] m2;

  always_comb begin
    consumed = cr_held && (text_byte == CH_LF);
    f1 = feed(quote_mode, consumed ? CH_LF : CH_CR, delim);
    v1 = cr_held && f1.emit;
    m1 = cr_held ? f1.mode : quote_mode;

    hold_cr = (text_byte == CH_CR) && !end_of_text;
    f2 = feed(m1, text_byte, delim);
    v2 = !consumed && !hold_cr && f2.emit;
    m2 = (!consumed && !hold_cr) ? f2.mode : m1;

    f3 = feed(m2, CH_LF, delim);
    v3 = end_of_text && (text_byte != CH_LF) && f3.emit;

    if (end_of_text) begin
      quote_mode_next = MODE_PLAIN;
      cr_held_next    = 1'b0;
    end else begin
      quote_mode_next = m2;
      cr_held_next    = !consumed && hold_cr;
    end

    ev[2] = f3.ev;
    ev[1] = (v1 && v2) ? f2.ev : f3.ev;
    ev[0] = v1 ? f1.ev : (v2 ? f2.ev : f3.ev);
    ev_cnt = {1'b0, v1} + {1'b0, v2} + {1'b0, v3};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      quote_mode <= MODE_PLAIN;
      cr_held    <= 1'b0;
      delim      <= DELIM_RESET;
    end else begin
      if (cfg_we) begin
        delim <= cfg_delim;
      end
      if (accept) begin
        quote_mode <= quote_mode_next;
        cr_held    <= cr_held_next;
      end
    end
  end

endmodule

@@ rtl/csvt_out_buf.sv @@
// ----------------------------------------------------------------------------
// csvt_out_buf
// Result register for up to three events of one byte, sent one per beat.
// ----------------------------------------------------------------------------
module csvt_out_buf (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   load,
  input  csvt_pkg::event_t       ev [csvt_pkg::MAX_EVENTS],
  input  logic [1:0]             ev_cnt,
  input  logic                   out_ready,
  output logic                   out_valid,
  output logic                   can_load,
  output csvt_pkg::event_t       head,
  output logic                   head_last,
  output csvt_pkg::buf_status_t  status
);
  import csvt_pkg::*;

  event_t     slot [MAX_EVENTS];
  logic [1:0] cnt;
  logic [1:0] rd;
  logic [1:0] rd_inc;

  assign rd_inc    = rd + 2'd1;
  assign out_valid = (rd != cnt);
  assign head_last = (rd_inc == cnt);
  assign can_load  = !out_valid || (head_last && out_ready);
  assign status    = '{cnt: cnt, rd: rd};

  always_comb begin
    case (rd)
      2'd0:    head = slot[0];
      2'd1:    head = slot[1];
      2'd2:    head = slot[2];
      default: head = slot[0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
      rd  <= 2'd0;
    end else if (load) begin
      cnt <= ev_cnt;
      rd  <= 2'd0;
    end else if (out_valid && out_ready) begin
      rd <= rd_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      slot <= ev;
    end
  end

endmodule

@@ rtl/csv_stream_tokenizer_core.sv @@
// ----------------------------------------------------------------------------
// csv_stream_tokenizer_core
// A byte's first event shows in the cycle after its beat is taken.
// One byte per cycle while out_ready is high and each byte gives at most
// one event; more events hold the input while the output register drains.
// Reset (rst, synchronous): unquoted mode, no held CR, delimiter ','.
// ----------------------------------------------------------------------------
module csv_stream_tokenizer_core (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] delimiter_char,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] text_byte,
  input  logic       end_of_text,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] event_kind,
  output logic [7:0] field_char,
  output logic       last_of_run
);
  import csvt_pkg::*;

  event_t      ev [MAX_EVENTS];
  logic [1:0]  ev_cnt;
  logic        accept;
  logic        can_load;
  event_t      head;
  buf_status_t status;

  assign cfg_ready  = 1'b1;
  assign in_ready   = can_load;
  assign accept     = in_valid && in_ready;
  assign event_kind = head.kind;
  assign field_char = head.ch;

  csvt_scan u_scan (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_valid && cfg_ready),
    .cfg_delim   (delimiter_char),
    .accept      (accept),
    .text_byte   (text_byte),
    .end_of_text (end_of_text),
    .ev          (ev),
    .ev_cnt      (ev_cnt)
  );

  csvt_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .load      (accept),
    .ev        (ev),
    .ev_cnt    (ev_cnt),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .can_load  (can_load),
    .head      (head),
    .head_last (last_of_run),
    .status    (status)
  );

`ifndef NO_ASSERTIONS
  a_rd_bound: assert property (@(posedge clk) disable iff (rst)
    status.rd <= status.cnt)
    else $error("read pointer past event count");

  a_nonchar_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && event_kind != KIND_CHAR) |-> field_char == 8'd0)
    else $error("separator event carries a character");

  a_drain_empty: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && last_of_run && !accept) |=> !out_valid)
    else $error("output still valid after last beat of a run");
`endif

endmodule
